// ----- rtl/asawm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC scan average monitor package
// Shared types, constants and the fixed slot to multiplexer map.
// ----------------------------------------------------------------------------
package asawm_pkg;

  localparam int NumSlots = 5;
  localparam int SlotW    = 3;
  localparam int SampleW  = 8;
  localparam int SumW     = 16;
  localparam int AvgW     = 8;
  localparam int MuxW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int TdataOutW = 48;

  // Register reset values
  localparam logic [SlotW-1:0]   RailAChanRst = 3'd0;
  localparam logic [AvgW-1:0]    RailALowRst  = 8'd155;
  localparam logic [AvgW-1:0]    RailAHighRst = 8'd175;
  localparam logic [SlotW-1:0]   RailBChanRst = 3'd1;
  localparam logic [AvgW-1:0]    RailBLowRst  = 8'd120;
  localparam logic [AvgW-1:0]    RailBHighRst = 8'd130;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRailAChan = 3'd0,
    CfgRailALow  = 3'd1,
    CfgRailAHigh = 3'd2,
    CfgRailBChan = 3'd3,
    CfgRailBLow  = 3'd4,
    CfgRailBHigh = 3'd5
  } cfg_idx_e;

  // Window settings for the two monitored rails
  typedef struct packed {
    logic [SlotW-1:0] a_chan;
    logic [AvgW-1:0]  a_low;
    logic [AvgW-1:0]  a_high;
    logic [SlotW-1:0] b_chan;
    logic [AvgW-1:0]  b_low;
    logic [AvgW-1:0]  b_high;
  } win_cfg_t;

  // Classified sample passed from front to back
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [SlotW-1:0]   slot;
    logic               done;
    logic [MuxW-1:0]    next_mux;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [MuxW-1:0]                next_mux;
    logic                           round_done;
    logic [NumSlots-1:0][AvgW-1:0]  avg;
    logic                           rail_a_ok;
    logic                           rail_b_ok;
  } result_t;

  // Fixed scan slot to multiplexer input map
  function automatic logic [MuxW-1:0] slot_mux(input logic [SlotW-1:0] slot);
    logic [MuxW-1:0] m;
    case (slot)
      3'd0:    m = 3'd0;
      3'd1:    m = 3'd1;
      3'd2:    m = 3'd4;
      3'd3:    m = 3'd5;
      3'd4:    m = 3'd6;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/asawm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC scan average monitor front end
// Accepts samples, tracks scan slot and round, and tags each sample with its
// slot, the end-of-period flag and the next multiplexer input.
// ----------------------------------------------------------------------------
module asawm_front #(
  parameter int AVG_DEPTH = 8,
  parameter int RndW      = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [asawm_pkg::SampleW-1:0]      sample_i,
  output logic                               push_o,
  output asawm_pkg::item_t                   item_o,
  input  logic                               full_i
);

  logic [asawm_pkg::SlotW-1:0] slot_q, slot_d;
  logic [RndW-1:0]             rnd_q, rnd_d;
  logic                        last_slot, last_rnd;

  assign s_ready_o = ~full_i;
  assign push_o    = s_valid_i & ~full_i;

  assign last_slot = (slot_q == asawm_pkg::SlotW'(asawm_pkg::NumSlots - 1));
  assign last_rnd  = (rnd_q == RndW'(AVG_DEPTH - 1));

  // Advance slot, then round on wrap
  always_comb begin
    slot_d = last_slot ? '0 : slot_q + 1'b1;
    rnd_d  = rnd_q;
    if (last_slot) begin
      rnd_d = last_rnd ? '0 : rnd_q + 1'b1;
    end
  end

  always_comb begin
    item_o.sample   = sample_i;
    item_o.slot     = slot_q;
    item_o.done     = last_slot & last_rnd;
    item_o.next_mux = asawm_pkg::slot_mux(slot_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      rnd_q  <= '0;
    end else if (push_o) begin
      slot_q <= slot_d;
      rnd_q  <= rnd_d;
    end
  end

endmodule

// ----- rtl/asawm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC scan average monitor item queue
// Two-entry queue decoupling the front end from the accumulator.
// ----------------------------------------------------------------------------
module asawm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  asawm_pkg::item_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output asawm_pkg::item_t rdata_o
);

  asawm_pkg::item_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/asawm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC scan average monitor back end
// Accumulates slot sums, forms averages and window flags at period end, and
// holds each result in an output register.
// ----------------------------------------------------------------------------
module asawm_back #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  asawm_pkg::item_t    item_i,
  output logic                pop_o,
  input  asawm_pkg::win_cfg_t cfg_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output asawm_pkg::result_t  result_o
);

  logic [asawm_pkg::SumW-1:0] sum_q [asawm_pkg::NumSlots];
  logic [asawm_pkg::SumW-1:0] upd_sum;
  logic [asawm_pkg::SumW-1:0] cur_sum [asawm_pkg::NumSlots];
  logic [asawm_pkg::NumSlots-1:0][asawm_pkg::AvgW-1:0] avg;
  logic [asawm_pkg::AvgW-1:0] avg_a, avg_b;
  logic                       a_ok, b_ok;
  logic                       out_valid_q;
  asawm_pkg::result_t         res_q, res_d;

  assign pop_o     = valid_i & (~out_valid_q | m_ready_i);
  assign m_valid_o = out_valid_q;
  assign result_o  = res_q;

  // Add sample into its slot and form averages from updated sums
  always_comb begin
    upd_sum = sum_q[item_i.slot] + asawm_pkg::SumW'(item_i.sample);
    for (int i = 0; i < asawm_pkg::NumSlots; i++) begin
      cur_sum[i] = (item_i.slot == asawm_pkg::SlotW'(i)) ? upd_sum : sum_q[i];
      avg[i]     = asawm_pkg::AvgW'(cur_sum[i] >> AVG_SHIFT);
    end
  end

  // Select rail averages; a channel beyond the last slot never passes
  always_comb begin
    avg_a = (cfg_i.a_chan < asawm_pkg::SlotW'(asawm_pkg::NumSlots))
            ? avg[cfg_i.a_chan] : '0;
    avg_b = (cfg_i.b_chan < asawm_pkg::SlotW'(asawm_pkg::NumSlots))
            ? avg[cfg_i.b_chan] : '0;
    a_ok  = (cfg_i.a_chan < asawm_pkg::SlotW'(asawm_pkg::NumSlots)) &&
            (avg_a >= cfg_i.a_low) && (avg_a <= cfg_i.a_high);
    b_ok  = (cfg_i.b_chan < asawm_pkg::SlotW'(asawm_pkg::NumSlots)) &&
            (avg_b >= cfg_i.b_low) && (avg_b <= cfg_i.b_high);
  end

  always_comb begin
    res_d            = '0;
    res_d.next_mux   = item_i.next_mux;
    res_d.round_done = item_i.done;
    if (item_i.done) begin
      res_d.avg       = avg;
      res_d.rail_a_ok = a_ok;
      res_d.rail_b_ok = b_ok;
    end
  end

  // Update sums; clear all at period end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < asawm_pkg::NumSlots; i++) sum_q[i] <= '0;
    end else if (pop_o) begin
      for (int i = 0; i < asawm_pkg::NumSlots; i++) begin
        sum_q[i] <= item_i.done ? '0 : cur_sum[i];
      end
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- rtl/adc_scan_average_window_monitor_top.sv -----
`timescale 1ns / 1ps
// Path: each accepted sample is queued, and its result beat is then registered.
// Throughput: one sample per cycle while the output is taken; the two-entry queue
// and the output register let input and output stall independently.
// Reset: asynchronous, active low; clears slot, round, sums, queue and the
// output valid, and loads the rail window registers with their defaults.
// ----------------------------------------------------------------------------
// ADC scan average monitor top level
// Five-slot scan averager with window checks on two selected supply rails.
// ----------------------------------------------------------------------------
module adc_scan_average_window_monitor_top #(
  parameter int AVG_DEPTH = 8,
  parameter int AVG_SHIFT = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // sample [7:0]
  input  logic [asawm_pkg::SampleW-1:0]        s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // next_mux_input [2:0], avg_slot0..4 [42:3], rail_a_ok [43], rail_b_ok [44]
  output logic [asawm_pkg::TdataOutW-1:0]      m_axis_tdata_o,
  // round_done
  output logic                                 m_axis_tlast_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [asawm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [asawm_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int RndW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  asawm_pkg::win_cfg_t cfg_q;
  asawm_pkg::item_t    push_item, pop_item;
  asawm_pkg::result_t  res;
  logic                push, full, pop, fifo_valid;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_chan <= asawm_pkg::RailAChanRst;
      cfg_q.a_low  <= asawm_pkg::RailALowRst;
      cfg_q.a_high <= asawm_pkg::RailAHighRst;
      cfg_q.b_chan <= asawm_pkg::RailBChanRst;
      cfg_q.b_low  <= asawm_pkg::RailBLowRst;
      cfg_q.b_high <= asawm_pkg::RailBHighRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        asawm_pkg::CfgRailAChan: cfg_q.a_chan <= cfg_data_i[asawm_pkg::SlotW-1:0];
        asawm_pkg::CfgRailALow:  cfg_q.a_low  <= cfg_data_i;
        asawm_pkg::CfgRailAHigh: cfg_q.a_high <= cfg_data_i;
        asawm_pkg::CfgRailBChan: cfg_q.b_chan <= cfg_data_i[asawm_pkg::SlotW-1:0];
        asawm_pkg::CfgRailBLow:  cfg_q.b_low  <= cfg_data_i;
        asawm_pkg::CfgRailBHigh: cfg_q.b_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  asawm_front #(
    .AVG_DEPTH (AVG_DEPTH),
    .RndW      (RndW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sample_i  (s_axis_tdata_i),
    .push_o    (push),
    .item_o    (push_item),
    .full_i    (full)
  );

  asawm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (pop_item)
  );

  asawm_back #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fifo_valid),
    .item_i    (pop_item),
    .pop_o     (pop),
    .cfg_i     (cfg_q),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .result_o  (res)
  );

  // Pack result beat
  assign m_axis_tdata_o = {3'b000, res.rail_b_ok, res.rail_a_ok,
                           res.avg[4], res.avg[3], res.avg[2], res.avg[1],
                           res.avg[0], res.next_mux};
  assign m_axis_tlast_o = res.round_done;

endmodule
